// File: sv/cal_pkg.sv
// shared types and constants for the cursor array list
// action and status codes, controller states, cell control bundle
// no dependencies
`timescale 1ns / 1ps

package cal_pkg;

    localparam int DATA_W = 32;
    localparam int CUR_W  = 6;
    localparam int CNT_W  = 7;
    localparam int ACT_W  = 4;
    localparam int ST_W   = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND     = 4'd0,
        ACT_FIRST      = 4'd1,
        ACT_LAST       = 4'd2,
        ACT_NEXT       = 4'd3,
        ACT_PREV       = 4'd4,
        ACT_READ       = 4'd5,
        ACT_REPLACE    = 4'd6,
        ACT_CLEAR      = 4'd7,
        ACT_MOVE_FIRST = 4'd8,
        ACT_MOVE_LAST  = 4'd9,
        ACT_MOVE_NEXT  = 4'd10,
        ACT_MOVE_PREV  = 4'd11,
        ACT_MOVE_POS   = 4'd12,
        ACT_DUMP       = 4'd13
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_END   = 3'd3,
        ST_START = 3'd4,
        ST_RANGE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_DUMP_RD,
        S_DUMP_WR
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_MOVE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                 op;
        logic [CUR_W-1:0]         addr;    // write address or move destination
        logic [CUR_W-1:0]         src;     // move source (current entry)
        logic                     fwd;     // destination above source
        logic signed [DATA_W-1:0] word;    // word to store at addr
        logic [CUR_W-1:0]         rd_idx;  // cell driving the read bus
    } cell_ctrl_t;

endpackage

// File: sv/cal_if.sv
// channel interfaces of the cursor array list
// command channel and response channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface cal_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic signed [31:0] value;
    logic [5:0]         position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface cal_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [5:0]         cursor;
    logic [6:0]         count;
    logic [2:0]         status;
    logic               last;

    modport source (output valid, output data, output cursor, output count, output status,
                    output last, input ready);
    modport sink   (input valid, input data, input cursor, input count, input status,
                    input last, output ready);
endinterface

// File: sv/cursor_array_list.sv
// top level of the cursor array list: sequencer, chain of entry cells, read tree
// depends on cal_pkg, cal_if, cal_cell and cal_ctrl
//
// usage
//   cmd carries one transaction per action: action code, value, position.
//   rsp returns one transaction per action (data, cursor, count, status,
//   last); a dump of a non-empty list returns count transactions in index
//   order with last on the final one.
// action sequence
//   a command is taken in S_IDLE, the current entry is read over the
//   registered read tree in S_FETCH, and the result is written into the
//   output register in S_EXEC; no new command is taken until that result
//   is loaded. a dump goes on through S_DUMP_RD to S_DUMP_WR, which loads
//   one entry per cycle while the output register is free, paced by the read
//   tree register. shifts of a move span any range at once along the chain.
// reset
//   rst_n clears state, cursor, count and output valid at once; entry words
//   and output payload are not cleared; words are read only once appended.
// stalls
//   a result waits in the output register while rsp.ready is low; the next
//   command is still taken, and work stops only when a new result is due.
`timescale 1ns / 1ps

module cursor_array_list
    import cal_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    cal_in_if.sink    cmd,
    cal_out_if.source rsp
);

    localparam int GROUP = 8;
    localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

    cell_ctrl_t               cell_ctrl;
    logic signed [DATA_W-1:0] words    [DEPTH];
    logic signed [DATA_W-1:0] rd_words [DEPTH];
    logic signed [DATA_W-1:0] grp_reg  [NGRP];
    logic signed [DATA_W-1:0] grp_next [NGRP];
    logic signed [DATA_W-1:0] rd_word;

    // sequencer
    cal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .rd_word   (rd_word),
        .cell_ctrl (cell_ctrl)
    );

    // chain of entry cells, each wired to its neighbors, zero beyond the ends
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = words[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = words[g+1];
        end

        cal_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[g]),
            .rd_word    (rd_words[g])
        );
    end

    // first read tree level: or of each group of cells
    always_comb
    begin
        for (int k = 0; k < NGRP; k++)
            grp_next[k] = '0;
        for (int i = 0; i < DEPTH; i++)
            grp_next[i / GROUP] = grp_next[i / GROUP] | rd_words[i];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NGRP; k++)
            grp_reg[k] <= grp_next[k];
    end

    // second read tree level
    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < NGRP; k++)
            rd_word = rd_word | grp_reg[k];
    end

endmodule

// File: sv/cal_cell.sv
// one entry cell of the list chain
// holds a word, loads it, or takes a neighbor's word during a move
// depends on cal_pkg
`timescale 1ns / 1ps

module cal_cell
    import cal_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] left_word,
    input  logic signed [DATA_W-1:0] right_word,
    output logic signed [DATA_W-1:0] word,
    output logic signed [DATA_W-1:0] rd_word
);

    localparam logic [CUR_W-1:0] IDX = CUR_W'(INDEX);

    logic signed [DATA_W-1:0] word_reg;
    logic signed [DATA_W-1:0] word_next;

    // next word from the broadcast command
    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_WRITE:
            begin
                if (ctrl.addr == IDX)
                    word_next = ctrl.word;
            end
            CELL_MOVE:
            begin
                if (ctrl.addr == IDX)
                    word_next = ctrl.word;
                else if (ctrl.fwd && IDX >= ctrl.src && IDX < ctrl.addr)
                    word_next = right_word;
                else if (!ctrl.fwd && IDX > ctrl.addr && IDX <= ctrl.src)
                    word_next = left_word;
            end
            default: ;
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (ctrl.rd_idx == IDX) ? word_reg : '0;

endmodule

// File: sv/cal_ctrl.sv
// sequencer of the cursor array list
// decodes actions, keeps cursor and count, drives the cell chain and output register
// depends on cal_pkg and the channel interfaces
`timescale 1ns / 1ps

module cal_ctrl
    import cal_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    cal_in_if.sink                   cmd,
    cal_out_if.source                rsp,
    input  logic signed [DATA_W-1:0] rd_word,
    output cell_ctrl_t               cell_ctrl
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                   state_reg, state_next;
    action_t                  act_reg, act_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CUR_W-1:0]         pos_reg, pos_next;
    logic [CUR_W-1:0]         cursor_reg, cursor_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CUR_W-1:0]         dump_reg, dump_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [CUR_W-1:0]         out_cursor_reg;
    logic [CNT_W-1:0]         out_count_reg;
    status_t                  out_status_reg;
    logic                     out_last_reg;

    logic                     load_out;
    logic signed [DATA_W-1:0] res_data;
    logic [CUR_W-1:0]         res_cursor;
    logic [CNT_W-1:0]         res_count;
    status_t                  res_status;
    logic                     res_last;
    logic                     out_free;

    logic [CNT_W-1:0]         n_last;
    logic [CUR_W-1:0]         last_idx;
    logic                     reloc;
    logic [CUR_W-1:0]         dst;
    status_t                  dec_status;
    logic signed [DATA_W-1:0] dec_data;
    logic [CUR_W-1:0]         dec_cursor;
    logic [CNT_W-1:0]         dec_count;
    cell_op_t                 dec_op;
    logic [CUR_W-1:0]         dec_addr;
    logic signed [DATA_W-1:0] dec_word;
    logic                     dec_dump;

    assign n_last   = count_reg - CNT_W'(1);
    assign last_idx = n_last[CUR_W-1:0];
    assign out_free = !out_valid_reg || rsp.ready;

    // action decode against the current cursor and count
    always_comb
    begin
        dec_status = ST_OK;
        dec_data   = '0;
        dec_cursor = cursor_reg;
        dec_count  = count_reg;
        dec_op     = CELL_HOLD;
        dec_addr   = cursor_reg;
        dec_word   = value_reg;
        dec_dump   = 1'b0;
        reloc      = 1'b0;
        dst        = cursor_reg;
        case (act_reg)
            ACT_APPEND:
            begin
                if (count_reg == FULL_CNT)
                    dec_status = ST_FULL;
                else
                begin
                    dec_op     = CELL_WRITE;
                    dec_addr   = count_reg[CUR_W-1:0];
                    dec_count  = count_reg + CNT_W'(1);
                    dec_cursor = count_reg[CUR_W-1:0];
                end
            end
            ACT_CLEAR:
            begin
                dec_count  = '0;
                dec_cursor = '0;
            end
            ACT_FIRST, ACT_LAST, ACT_NEXT, ACT_PREV, ACT_READ, ACT_REPLACE,
            ACT_MOVE_FIRST, ACT_MOVE_LAST, ACT_MOVE_NEXT, ACT_MOVE_PREV,
            ACT_MOVE_POS, ACT_DUMP:
            begin
                if (count_reg == '0)
                    dec_status = ST_EMPTY;
                else
                begin
                    case (act_reg)
                        ACT_FIRST: dec_cursor = '0;
                        ACT_LAST:  dec_cursor = last_idx;
                        ACT_NEXT:
                        begin
                            if ({1'b0, cursor_reg} >= n_last)
                                dec_status = ST_END;
                            else
                                dec_cursor = cursor_reg + CUR_W'(1);
                        end
                        ACT_PREV:
                        begin
                            if (cursor_reg == '0)
                                dec_status = ST_START;
                            else
                                dec_cursor = cursor_reg - CUR_W'(1);
                        end
                        ACT_READ:    dec_data = rd_word;
                        ACT_REPLACE: dec_op   = CELL_WRITE;
                        ACT_MOVE_FIRST:
                        begin
                            reloc = 1'b1;
                            dst   = '0;
                        end
                        ACT_MOVE_LAST:
                        begin
                            reloc = 1'b1;
                            dst   = last_idx;
                        end
                        ACT_MOVE_NEXT:
                        begin
                            if ({1'b0, cursor_reg} >= n_last)
                                dec_status = ST_END;
                            else
                            begin
                                reloc = 1'b1;
                                dst   = cursor_reg + CUR_W'(1);
                            end
                        end
                        ACT_MOVE_PREV:
                        begin
                            if (cursor_reg == '0)
                                dec_status = ST_START;
                            else
                            begin
                                reloc = 1'b1;
                                dst   = cursor_reg - CUR_W'(1);
                            end
                        end
                        ACT_MOVE_POS:
                        begin
                            if ({1'b0, pos_reg} >= count_reg)
                                dec_status = ST_RANGE;
                            else
                            begin
                                reloc = 1'b1;
                                dst   = pos_reg;
                            end
                        end
                        ACT_DUMP: dec_dump = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // relocation: held word goes to the destination, cursor follows it
        if (reloc)
        begin
            dec_op     = CELL_MOVE;
            dec_addr   = dst;
            dec_word   = rd_word;
            dec_cursor = dst;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        dump_next   = dump_reg;
        cmd.ready   = 1'b0;
        load_out    = 1'b0;
        res_data    = dec_data;
        res_cursor  = dec_cursor;
        res_count   = dec_count;
        res_status  = dec_status;
        res_last    = 1'b1;
        cell_ctrl.op     = CELL_HOLD;
        cell_ctrl.addr   = dec_addr;
        cell_ctrl.src    = cursor_reg;
        cell_ctrl.fwd    = dec_addr > cursor_reg;
        cell_ctrl.word   = dec_word;
        cell_ctrl.rd_idx = cursor_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    act_next   = action_t'(cmd.action);
                    value_next = cmd.value;
                    pos_next   = cmd.position;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (dec_dump)
                begin
                    dump_next  = '0;
                    state_next = S_DUMP_RD;
                end
                else if (out_free)
                begin
                    load_out     = 1'b1;
                    cursor_next  = dec_cursor;
                    count_next   = dec_count;
                    cell_ctrl.op = dec_op;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                cell_ctrl.rd_idx = dump_reg;
                state_next       = S_DUMP_WR;
            end
            S_DUMP_WR:
            begin
                cell_ctrl.rd_idx = dump_reg;
                res_data   = rd_word;
                res_cursor = cursor_reg;
                res_count  = count_reg;
                res_status = ST_OK;
                res_last   = (dump_reg == last_idx);
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (res_last)
                        state_next = S_IDLE;
                    else
                    begin
                        dump_next        = dump_reg + CUR_W'(1);
                        cell_ctrl.rd_idx = dump_reg + CUR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // transaction payload and dump index
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        dump_reg  <= dump_next;
        if (load_out)
        begin
            out_data_reg   <= res_data;
            out_cursor_reg <= res_cursor;
            out_count_reg  <= res_count;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.cursor = out_cursor_reg;
    assign rsp.count  = out_count_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

endmodule

// File: sv/cal_checker.sv
// port level checks for the cursor array list, bound to the top level
// tracks open transactions between the command and response channels
// depends on cursor_array_list
`timescale 1ns / 1ps

module cal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_data,
    input logic [5:0]  rsp_cursor,
    input logic [6:0]  rsp_count,
    input logic [2:0]  rsp_status,
    input logic        rsp_last
);

    logic [1:0] pend_reg;
    logic       cmd_take;
    logic       rsp_done;

    assign cmd_take = cmd_valid && cmd_ready;
    assign rsp_done = rsp_valid && rsp_ready && rsp_last;

    // commands whose final response has not been taken yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (cmd_take && !rsp_done)
            pend_reg <= pend_reg + 2'd1;
        else if (!cmd_take && rsp_done)
            pend_reg <= pend_reg - 2'd1;
    end

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_cursor)
            && $stable(rsp_count) && $stable(rsp_status) && $stable(rsp_last))
        else $error("response changed while stalled");

    // no response without an open command
    a_rsp_owned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0 || cmd_take)
        else $error("response without an open command");

    // at most one command in work beside a waiting result
    a_cmd_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> pend_reg < 2'd2)
        else $error("command taken with two open transactions");

    // the cursor stays inside the list
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_count == 7'd0 && rsp_cursor == 6'd0)
            || ({1'b0, rsp_cursor} < rsp_count))
        else $error("cursor outside the list");

endmodule

bind cursor_array_list cal_checker u_cal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_data   (rsp.data),
    .rsp_cursor (rsp.cursor),
    .rsp_count  (rsp.count),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last)
);
